>>> hdl/ilr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed list with rotate.
// Used by ilr_cell, ilr_mod, indexed_list_with_rotate and the testbench; depends on nothing.

package ilr_pkg;

    localparam int POS_W   = 5;
    localparam int PORT_IW = 32;
    localparam int LEN_W   = 5;
    localparam int TURN_W  = 16;
    localparam int TCNT_W  = $clog2(TURN_W);

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_GET    = 2'd2,
        ACT_ROTATE = 2'd3
    } act_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MOD  = 5'b00100,
        S_ROT  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctl_t;

endpackage

>>> hdl/ilr_cell.sv
`timescale 1ns / 1ps
// One list entry of the cell chain: takes a new item, its left neighbor on insert,
// or its right neighbor (the front item at the back end) on a rotate step. Uses ilr_pkg.

module ilr_cell #(
    parameter int ITEM_WIDTH = 32,
    parameter int IW         = 4,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  ilr_pkg::cell_ctl_t    ctl,
    input  logic [IW-1:0]         pos,
    input  logic [IW-1:0]         last,
    input  logic [ITEM_WIDTH-1:0] new_item,
    input  logic [ITEM_WIDTH-1:0] left_data,
    input  logic [ITEM_WIDTH-1:0] right_data,
    input  logic [ITEM_WIDTH-1:0] head_data,
    output logic [ITEM_WIDTH-1:0] data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ITEM_WIDTH-1:0] data_reg;
    logic [ITEM_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.insert)
        begin
            if (MY_IDX == pos)
            begin
                data_next = new_item;
            end
            else if (MY_IDX > pos)
            begin
                data_next = left_data;
            end
        end
        else if (ctl.rotate)
        begin
            if (MY_IDX == last)
            begin
                data_next = head_data;
            end
            else
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hdl/ilr_mod.sv
`timescale 1ns / 1ps
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Uses ilr_pkg for the dividend width.

module ilr_mod #(
    parameter int CW = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ilr_pkg::TURN_W-1:0] dividend,
    input  logic [CW-1:0]              divisor,
    output logic                       done,
    output logic [CW-1:0]              remainder
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [ilr_pkg::TCNT_W-1:0] cnt_reg;
    logic [ilr_pkg::TCNT_W-1:0] cnt_next;
    logic [ilr_pkg::TURN_W-1:0] dvd_reg;
    logic [ilr_pkg::TURN_W-1:0] dvd_next;
    logic [CW-1:0]              dvs_reg;
    logic [CW-1:0]              dvs_next;
    logic [CW-1:0]              rem_reg;
    logic [CW-1:0]              rem_next;
    logic [CW:0]                shifted;

    assign shifted = {rem_reg, dvd_reg[ilr_pkg::TURN_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ilr_pkg::TCNT_W'(ilr_pkg::TURN_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ilr_pkg::TURN_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = CW'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = CW'(shifted);
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/indexed_list_with_rotate.sv
`timescale 1ns / 1ps
// Top level of the indexed list with rotate: control, cell chain and modulo unit.
// Depends on ilr_pkg, ilr_cell and ilr_mod.

// The list is held in a chain of DEPTH cells in list order, cell 0 being the front.
// Each request is one transaction in and one transaction out. Append, insert and get
// are executed and their result is loaded into the output register; insert shifts
// all later cells back by one in the same step. A rotate on a list of two or more
// items first has the bit-serial modulo unit reduce rotate_by mod length to a move
// count, then the chain makes one front-to-back move per cycle.
// A new transaction is taken while the previous result still waits in the output
// register; only one request is in work at a time.

module indexed_list_with_rotate #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [ilr_pkg::POS_W-1:0]   position,
    input  logic [ilr_pkg::PORT_IW-1:0] new_item,
    input  logic [ilr_pkg::TURN_W-1:0]  rotate_by,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [ilr_pkg::PORT_IW-1:0] read_item,
    output logic [ilr_pkg::LEN_W-1:0]   length_now
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ilr_pkg::POS_W) ? CW : ilr_pkg::POS_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ilr_pkg::state_t            state_reg;
    ilr_pkg::state_t            state_next;
    ilr_pkg::act_t              act_reg;
    logic [ilr_pkg::POS_W-1:0]  pos_reg;
    logic [ITEM_WIDTH-1:0]      item_reg;
    logic [ilr_pkg::TURN_W-1:0] turns_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              rot_left_reg;
    logic [CW-1:0]              rot_left_next;
    logic                       res_ok_reg;
    logic                       res_ok_next;
    logic [ITEM_WIDTH-1:0]      res_item_reg;
    logic [ITEM_WIDTH-1:0]      res_item_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_ok_reg;
    logic [ilr_pkg::PORT_IW-1:0] out_item_reg;
    logic [ilr_pkg::LEN_W-1:0]  out_len_reg;
    logic                       out_load;

    ilr_pkg::cell_ctl_t         ctl;
    logic [IW-1:0]              ins_pos;
    logic [IW-1:0]              last_idx;
    logic [CMPW-1:0]            pos_cmp;
    logic [CMPW-1:0]            cnt_cmp;
    logic                       mod_start;
    logic                       mod_done;
    logic [CW-1:0]              mod_rem;
    logic                       in_fire;
    logic [ITEM_WIDTH-1:0]      cell_data [DEPTH];

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ilr_pkg::S_IDLE);
    assign pos_cmp  = CMPW'(pos_reg);
    assign cnt_cmp  = CMPW'(count_reg);
    assign last_idx = IW'(count_reg - 1'b1);
    assign ins_pos  = (act_reg == ilr_pkg::ACT_APPEND) ? IW'(count_reg) : IW'(pos_reg);
    assign out_load = (state_reg == ilr_pkg::S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rot_left_next = rot_left_reg;
        res_ok_next   = res_ok_reg;
        res_item_next = res_item_reg;
        ctl           = '0;
        mod_start     = 1'b0;
        case (state_reg)
            ilr_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ilr_pkg::S_EXEC;
                end
            end
            ilr_pkg::S_EXEC:
            begin
                res_ok_next   = 1'b0;
                res_item_next = '0;
                state_next    = ilr_pkg::S_DONE;
                case (act_reg)
                    ilr_pkg::ACT_APPEND:
                    begin
                        if (count_reg < FULL)
                        begin
                            ctl.insert  = 1'b1;
                            count_next  = count_reg + 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    ilr_pkg::ACT_INSERT:
                    begin
                        if ((count_reg < FULL) && (pos_cmp <= cnt_cmp))
                        begin
                            ctl.insert  = 1'b1;
                            count_next  = count_reg + 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    ilr_pkg::ACT_GET:
                    begin
                        if (pos_cmp < cnt_cmp)
                        begin
                            res_ok_next   = 1'b1;
                            res_item_next = cell_data[IW'(pos_reg)];
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b1;
                        if (count_reg > CW'(1))
                        begin
                            mod_start  = 1'b1;
                            state_next = ilr_pkg::S_MOD;
                        end
                    end
                endcase
            end
            ilr_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    rot_left_next = mod_rem;
                    state_next    = ilr_pkg::S_ROT;
                end
            end
            ilr_pkg::S_ROT:
            begin
                if (rot_left_reg == '0)
                begin
                    state_next = ilr_pkg::S_DONE;
                end
                else
                begin
                    ctl.rotate    = 1'b1;
                    rot_left_next = rot_left_reg - 1'b1;
                end
            end
            ilr_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = ilr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ilr_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilr_pkg::S_IDLE;
            count_reg     <= '0;
            rot_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_left_reg  <= rot_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= ilr_pkg::act_t'(action);
            pos_reg   <= position;
            item_reg  <= ITEM_WIDTH'(new_item);
            turns_reg <= rotate_by;
        end
        res_ok_reg   <= res_ok_next;
        res_item_reg <= res_item_next;
        if (out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_item_reg <= ilr_pkg::PORT_IW'(res_item_reg);
            out_len_reg  <= ilr_pkg::LEN_W'(count_reg);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ITEM_WIDTH-1:0] left_d;
            logic [ITEM_WIDTH-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_inner
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign right_d = cell_data[0];
            end
            else
            begin : g_mid
                assign right_d = cell_data[gi+1];
            end
            ilr_cell #(
                .ITEM_WIDTH (ITEM_WIDTH),
                .IW         (IW),
                .IDX        (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (ins_pos),
                .last       (last_idx),
                .new_item   (item_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    ilr_mod #(
        .CW (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (turns_reg),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign read_item  = out_item_reg;
    assign length_now = out_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("List length exceeds the number of cells.");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ilr_pkg::S_EXEC))
        else $error("Accepted transaction did not enter execution.");

    a_rot_needs_items: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rotate |-> (count_reg > CW'(1)))
        else $error("Rotate step on a list of fewer than two items.");

    a_rot_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ilr_pkg::S_ROT) |-> (rot_left_reg < count_reg))
        else $error("Remaining rotate moves not below the list length.");

    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!ctl.insert && !ctl.rotate))
        else $error("Result loaded while the chain is still moving.");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_with_rotate: a directed table, then random requests.
// Depends on ilr_pkg and the indexed_list_with_rotate RTL.

module testbench;

    localparam int DEPTH          = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 2000;

    typedef struct packed {
        ilr_pkg::act_t act;
        logic [4:0]    pos;
        logic [31:0]   item;
        logic [15:0]   turns;
    } list_request_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read;
        logic [4:0]  len;
    } list_result_t;

    typedef struct packed {
        list_request_t req;
        logic [7:0]    reps;
        logic          typed;
        list_result_t  res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [4:0]  position;
    logic [31:0] new_item;
    logic [15:0] rotate_by;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [31:0] read_item;
    logic [4:0]  length_now;

    logic [31:0]  list_slots [DEPTH];
    int           front_slot;
    int           list_len;
    list_result_t pending_results [$];
    list_result_t oldest_result;
    table_row_t   stimulus_table [$];
    int           mismatches;
    int           results_checked;
    int           quiet_cycles;
    int           burst_left;

    indexed_list_with_rotate #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (32)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .position   (position),
        .new_item   (new_item),
        .rotate_by  (rotate_by),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_item  (read_item),
        .length_now (length_now)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_result_t predict_list(input list_request_t r);
        list_result_t res;
        int k;
        int moves;
        res = '0;
        case (r.act)
            ilr_pkg::ACT_APPEND:
            begin
                if (list_len < DEPTH)
                begin
                    list_slots[(front_slot + list_len) % DEPTH] = r.item;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            ilr_pkg::ACT_INSERT:
            begin
                if (list_len < DEPTH && int'(r.pos) <= list_len)
                begin
                    for (k = list_len; k > int'(r.pos); k--)
                        list_slots[(front_slot + k) % DEPTH] =
                            list_slots[(front_slot + k - 1) % DEPTH];
                    list_slots[(front_slot + int'(r.pos)) % DEPTH] = r.item;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            ilr_pkg::ACT_GET:
            begin
                if (int'(r.pos) < list_len)
                begin
                    res.read = list_slots[(front_slot + int'(r.pos)) % DEPTH];
                    res.ok   = 1'b1;
                end
            end
            default:
            begin
                res.ok = 1'b1;
                if (list_len > 1)
                begin
                    moves = int'(r.turns) % list_len;
                    for (k = 0; k < moves; k++)
                    begin
                        list_slots[(front_slot + list_len) % DEPTH] = list_slots[front_slot];
                        front_slot = (front_slot + 1) % DEPTH;
                    end
                end
            end
        endcase
        res.len = 5'(list_len);
        return res;
    endfunction

    task automatic add_row(input ilr_pkg::act_t act, input int pos, input logic [31:0] item,
                           input int turns, input int reps, input bit typed,
                           input bit want_ok, input logic [31:0] want_read, input int want_len);
        table_row_t row;
        row.req   = '{act, 5'(pos), item, 16'(turns)};
        row.reps  = 8'(reps);
        row.typed = typed;
        row.res   = '{want_ok, want_read, 5'(want_len)};
        stimulus_table.push_back(row);
    endtask

    // Hold one request on the input until the block takes it, then record what it should return.
    task automatic offer(input list_request_t r, input bit typed, input list_result_t typed_res);
        list_result_t predicted;
        in_valid  <= 1'b1;
        action    <= r.act;
        position  <= r.pos;
        new_item  <= r.item;
        rotate_by <= r.turns;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predicted = predict_list(r);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid  <= 1'b0;
                action    <= 2'($urandom_range(0, 3));
                position  <= 5'($urandom);
                new_item  <= $urandom;
                rotate_by <= 16'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic list_request_t random_request();
        list_request_t r;
        int sel;
        sel     = $urandom_range(0, 99);
        r.item  = $urandom;
        r.pos   = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, 15))
                                               : 5'($urandom_range(16, 31));
        r.turns = 16'($urandom_range(0, 40));
        if (sel < 45)
        begin
            r.act = ilr_pkg::ACT_GET;
        end
        else if (sel < 80)
        begin
            r.act = ilr_pkg::ACT_ROTATE;
            sel   = $urandom_range(0, 9);
            if (sel < 3)
                r.turns = 16'($urandom);
            else if (sel < 5)
                r.turns = 16'(DEPTH * $urandom_range(0, 4095));
        end
        else if (sel < 90)
        begin
            r.act = ilr_pkg::ACT_APPEND;
        end
        else
        begin
            r.act = ilr_pkg::ACT_INSERT;
            r.pos = 5'($urandom);
        end
        return r;
    endfunction

    initial
    begin : stimulus
        table_row_t    row;
        list_request_t req;
        int            rep;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ilr_pkg::ACT_APPEND;
        position   <= '0;
        new_item   <= '0;
        rotate_by  <= '0;
        mismatches = 0;
        burst_left = 0;
        front_slot = 0;
        list_len   = 0;
        foreach (list_slots[i])
            list_slots[i] = '0;

        add_row(ilr_pkg::ACT_GET,    0,  32'h0,        0,     1,  1, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        5,     1,  1, 1, 32'h0,        0);
        add_row(ilr_pkg::ACT_INSERT, 1,  32'h1111_1111, 0,    1,  1, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_INSERT, 0,  32'hFFFF_FFFF, 0,    1,  1, 1, 32'h0,        1);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        65535, 1,  1, 1, 32'h0,        1);
        add_row(ilr_pkg::ACT_GET,    0,  32'h0,        0,     1,  1, 1, 32'hFFFF_FFFF, 1);
        add_row(ilr_pkg::ACT_APPEND, 0,  32'h0,        0,     1,  1, 1, 32'h0,        2);
        add_row(ilr_pkg::ACT_INSERT, 2,  32'hA5A5_A5A5, 0,    1,  1, 1, 32'h0,        3);
        add_row(ilr_pkg::ACT_INSERT, 1,  32'h1234_5678, 0,    1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_GET,    1,  32'h0,        0,     1,  1, 1, 32'h1234_5678, 4);
        add_row(ilr_pkg::ACT_GET,    4,  32'h0,        0,     1,  1, 0, 32'h0,        4);
        add_row(ilr_pkg::ACT_GET,    31, 32'hFFFF_FFFF, 65535, 1, 1, 0, 32'h0,        4);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        0,     1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        4,     1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        65535, 1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_GET,    0,  32'h0,        0,     1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_INSERT, 0,  32'h8000_0000, 0,    4,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_APPEND, 0,  32'h5555_0000, 0,    4,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_INSERT, 2,  32'h0F0F_0000, 0,    4,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_APPEND, 0,  32'hDEAD_BEEF, 0,    1,  1, 0, 32'h0,        16);
        add_row(ilr_pkg::ACT_INSERT, 16, 32'hDEAD_BEEF, 0,    1,  1, 0, 32'h0,        16);
        add_row(ilr_pkg::ACT_INSERT, 0,  32'hDEAD_BEEF, 0,    1,  1, 0, 32'h0,        16);
        add_row(ilr_pkg::ACT_GET,    16, 32'h0,        0,     1,  1, 0, 32'h0,        16);
        add_row(ilr_pkg::ACT_ROTATE, 0,  32'h0,        17,    1,  0, 0, 32'h0,        0);
        add_row(ilr_pkg::ACT_GET,    15, 32'h0,        0,     1,  0, 0, 32'h0,        0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_table[i])
        begin
            row = stimulus_table[i];
            for (rep = 0; rep < int'(row.reps); rep++)
            begin
                req      = row.req;
                req.item = row.req.item + 32'(rep);
                offer(req, row.typed, row.res);
                pace_sender();
            end
        end

        repeat (RANDOM_ITEMS)
        begin
            offer(random_request(), 1'b0, '0);
            pace_sender();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("indexed_list_with_rotate test passed");
        else
            $display("indexed_list_with_rotate test failed");
        $finish;
    end

    initial
    begin : result_sink
        int  span;
        int  mode;
        bit  held_once;
        held_once = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_once && results_checked >= 500)
            begin
                held_once = 1'b1;
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            span = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    initial
    begin
        results_checked = 0;
    end

    // Outputs change only after a rising edge, so the values seen at the falling edge
    // are those that the next rising edge takes.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("extra result transaction: ok=%0b read_item=%h length_now=%0d",
                       ok, read_item, length_now);
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (ok !== oldest_result.ok)
                begin
                    $error("ok: expected %0b, got %0b", oldest_result.ok, ok);
                    mismatches++;
                end
                if (read_item !== oldest_result.read)
                begin
                    $error("read_item: expected %h, got %h", oldest_result.read, read_item);
                    mismatches++;
                end
                if (length_now !== oldest_result.len)
                begin
                    $error("length_now: expected %0d, got %0d", oldest_result.len, length_now);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("indexed_list_with_rotate test failed");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/ilr_pkg.sv
hdl/ilr_cell.sv
hdl/ilr_mod.sv
hdl/indexed_list_with_rotate.sv
tb/testbench.sv
